// ===== rtl/three_phase_sine_pwm_generator_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef THREE_PHASE_SINE_PWM_GENERATOR_ASSERT_SVH
`define THREE_PHASE_SINE_PWM_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle port check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle port check failed");

`endif

// ===== rtl/tps_pkg.sv =====
package tps_pkg;

    localparam int TABLE_MAX_DEF     = 1024;
    localparam int PERIOD_COUNTS_DEF = 32768;

    localparam int MOD_W   = 17;
    localparam int STEPS_W = 11;
    localparam int CFG_W   = 17;
    localparam int CMP_W   = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_POLL  = 2'd3;

    localparam logic [1:0] RUN_STATE_IDLE  = 2'd0;
    localparam logic [1:0] RUN_STATE_RUN   = 2'd1;
    localparam logic [1:0] RUN_STATE_FAULT = 2'd2;

    localparam logic CFG_MOD_IDX   = 1'b0;
    localparam logic CFG_STEPS_IDX = 1'b1;

    localparam logic [MOD_W-1:0]   MOD_RESET   = 17'd58982;
    localparam logic [MOD_W-1:0]   MOD_ONE     = 17'h10000;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd1024;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_alu_rsp;

    typedef logic [2:0][CMP_W-1:0] t_cmp3;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_FAULT = 3'b100
    } t_mode;

    // Divisor k*(k+1) of the series term with index k.
    function automatic logic [7:0] term_div(input logic [3:0] k);
        logic [7:0] kk;
        kk = {4'd0, k};
        return kk * (kk + 8'd1);
    endfunction

endpackage

// ===== rtl/tps_alu.sv =====
module tps_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tps_pkg::t_alu_req i_req,
    output tps_pkg::t_alu_rsp o_rsp
);
    import tps_pkg::*;

    logic        r_run;
    logic        r_done;
    logic [4:0]  r_cnt;
    t_alu_op     r_op;
    logic [31:0] r_opd;
    logic [31:0] r_hi;
    logic [31:0] r_lo;

    logic        sub;
    logic        ge;
    logic [33:0] add_a;
    logic [33:0] add_b;
    logic [33:0] sum;
    logic [31:0] n_hi;
    logic [31:0] n_lo;

    always_comb begin
        sub   = (r_op == ALU_DIV);
        add_a = sub ? {1'b0, r_hi, r_lo[31]} : {2'b00, r_hi};
        add_b = {2'b00, (sub || r_lo[0]) ? r_opd : 32'd0};
        sum   = add_a + (sub ? ~add_b : add_b) + {33'd0, sub};
        ge    = !sum[33];
        if (sub) begin
            n_hi = ge ? sum[31:0] : {r_hi[30:0], r_lo[31]};
            n_lo = {r_lo[30:0], ge};
        end else begin
            n_hi = sum[32:1];
            n_lo = {sum[0], r_lo[31:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_opd <= i_req.a;
            r_lo  <= i_req.b;
            r_hi  <= 32'd0;
        end else if (r_run) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = {r_hi, r_lo};

endmodule

// ===== rtl/tps_seq.sv =====
module tps_seq #(
    parameter int TABLE_MAX     = tps_pkg::TABLE_MAX_DEF,
    parameter int PERIOD_COUNTS = tps_pkg::PERIOD_COUNTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(TABLE_MAX)-1:0]   i_idx,
    input  logic [$clog2(TABLE_MAX+1)-1:0] i_n,
    input  logic [tps_pkg::MOD_W-1:0]      i_mod,
    output logic                           o_done,
    output tps_pkg::t_cmp3                 o_cmp,
    output tps_pkg::t_alu_req              o_req,
    input  tps_pkg::t_alu_rsp              i_rsp
);
    import tps_pkg::*;

    localparam int IW = $clog2(TABLE_MAX);
    localparam int NW = $clog2(TABLE_MAX + 1);
    localparam logic [31:0]        HALF_W  = 32'(PERIOD_COUNTS / 2);
    localparam logic signed [18:0] HALF_S  = 19'(PERIOD_COUNTS / 2);
    localparam logic signed [18:0] CMP_MAX = 19'(PERIOD_COUNTS - 1);
    localparam logic signed [18:0] CMP_MIN = 19'sd1;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_N3   = 11'b000_0000_0010,
        S_N23  = 11'b000_0000_0100,
        S_ANG  = 11'b000_0000_1000,
        S_RAD  = 11'b000_0001_0000,
        S_SQR  = 11'b000_0010_0000,
        S_TMUL = 11'b000_0100_0000,
        S_TDIV = 11'b000_1000_0000,
        S_MAG  = 11'b001_0000_0000,
        S_PM1  = 11'b010_0000_0000,
        S_PM2  = 11'b100_0000_0000
    } t_seq_state;

    t_seq_state r_state, n_state;
    logic       r_wait, n_wait;
    logic       r_done, n_done;

    logic [1:0]         r_phase, n_phase;
    logic [IW-1:0]      r_ia, n_ia;
    logic [IW-1:0]      r_i, n_i;
    logic [NW-1:0]      r_n3, n_n3;
    logic [NW-1:0]      r_n23, n_n23;
    logic [13:0]        r_tt, n_tt;
    logic               r_cos, n_cos;
    logic               r_sgn, n_sgn;
    logic [29:0]        r_x, n_x;
    logic [29:0]        r_x2, n_x2;
    logic [30:0]        r_term, n_term;
    logic signed [32:0] r_sum, n_sum;
    logic [3:0]         r_k, n_k;
    logic [2:0]         r_cnt, n_cnt;
    logic [14:0]        r_m, n_m;
    logic [31:0]        r_pm1, n_pm1;
    t_cmp3              r_cmp, n_cmp;

    logic [63:0]        res;
    logic [14:0]        t15;
    logic               w_cos;
    logic [45:0]        rad_w;
    logic [45:0]        mag_w;
    logic [48:0]        neg_w;
    logic signed [18:0] c_raw;
    logic [15:0]        c_sat;
    logic signed [32:0] sum_step;
    logic [30:0]        v_sat;
    logic [NW:0]        nxt_sum;
    logic [NW:0]        nxt_idx;

    always_comb begin
        res   = i_rsp.res;
        t15   = res[14] ? (15'd16384 - {1'b0, res[13:0]}) : {1'b0, res[13:0]};
        w_cos = (t15 > 15'd8192);
        rad_w = res[45:0] + 46'd16384;
        mag_w = res[45:0] + 46'h2000_0000;
        neg_w = {1'b0, res[47:0]} + 49'h0_7FFF_FFFF;
        if (r_sgn) begin
            c_raw = HALF_S - signed'({1'b0, neg_w[48:31]});
        end else begin
            c_raw = HALF_S + signed'({2'b00, res[47:31]});
        end
        if (c_raw < CMP_MIN) begin
            c_sat = 16'(CMP_MIN);
        end else if (c_raw > CMP_MAX) begin
            c_sat = 16'(CMP_MAX);
        end else begin
            c_sat = c_raw[15:0];
        end
        if (r_cnt[0]) begin
            sum_step = r_sum + signed'({2'b00, res[30:0]});
        end else begin
            sum_step = r_sum - signed'({2'b00, res[30:0]});
        end
        if (sum_step < 33'sd0) begin
            v_sat = 31'd0;
        end else if (sum_step > signed'({1'b0, ONE_Q30})) begin
            v_sat = ONE_Q30[30:0];
        end else begin
            v_sat = sum_step[30:0];
        end
        nxt_sum = (NW+1)'(r_ia) + {1'b0, (r_phase == 2'd0) ? r_n3 : r_n23};
        nxt_idx = (nxt_sum >= {1'b0, i_n}) ? (nxt_sum - {1'b0, i_n}) : nxt_sum;
    end

    always_comb begin
        o_req.start = (r_state != S_IDLE) && !r_wait;
        o_req.op    = ALU_MUL;
        o_req.a     = 32'd0;
        o_req.b     = 32'd0;
        unique case (r_state)
            S_N3: begin
                o_req.op = ALU_DIV;
                o_req.a  = 32'd3;
                o_req.b  = 32'(i_n);
            end
            S_N23: begin
                o_req.op = ALU_DIV;
                o_req.a  = 32'd3;
                o_req.b  = 32'({i_n, 1'b0});
            end
            S_ANG: begin
                o_req.op = ALU_DIV;
                o_req.a  = 32'(i_n);
                o_req.b  = 32'({r_i, 16'h0000});
            end
            S_RAD: begin
                o_req.a = PI_Q30;
                o_req.b = 32'(r_tt);
            end
            S_SQR: begin
                o_req.a = 32'(r_x);
                o_req.b = 32'(r_x);
            end
            S_TMUL: begin
                o_req.a = 32'(r_term);
                o_req.b = 32'(r_x2);
            end
            S_TDIV: begin
                o_req.op = ALU_DIV;
                o_req.a  = 32'(term_div(r_k));
                o_req.b  = 32'(r_term);
            end
            S_MAG: begin
                o_req.a = 32'd32767;
                o_req.b = 32'(r_term);
            end
            S_PM1: begin
                o_req.a = 32'(i_mod);
                o_req.b = 32'(r_m);
            end
            S_PM2: begin
                o_req.a = HALF_W;
                o_req.b = r_pm1;
            end
            default: begin
                o_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_done  = 1'b0;
        n_phase = r_phase;
        n_ia    = r_ia;
        n_i     = r_i;
        n_n3    = r_n3;
        n_n23   = r_n23;
        n_tt    = r_tt;
        n_cos   = r_cos;
        n_sgn   = r_sgn;
        n_x     = r_x;
        n_x2    = r_x2;
        n_term  = r_term;
        n_sum   = r_sum;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_m     = r_m;
        n_pm1   = r_pm1;
        n_cmp   = r_cmp;
        if (r_state == S_IDLE) begin
            if (i_start) begin
                n_ia    = i_idx;
                n_state = S_N3;
            end
        end else if (!r_wait) begin
            n_wait = 1'b1;
        end else if (i_rsp.done) begin
            n_wait = 1'b0;
            unique case (r_state)
                S_N3: begin
                    n_n3    = res[NW-1:0];
                    n_state = S_N23;
                end
                S_N23: begin
                    n_n23   = res[NW-1:0];
                    n_phase = 2'd0;
                    n_i     = r_ia;
                    n_state = S_ANG;
                end
                S_ANG: begin
                    n_sgn   = res[15];
                    n_cos   = w_cos;
                    n_tt    = w_cos ? 14'(15'd16384 - t15) : t15[13:0];
                    n_state = S_RAD;
                end
                S_RAD: begin
                    n_x     = rad_w[44:15];
                    n_state = S_SQR;
                end
                S_SQR: begin
                    n_x2    = res[59:30];
                    n_term  = r_cos ? ONE_Q30[30:0] : {1'b0, r_x};
                    n_sum   = r_cos ? signed'({1'b0, ONE_Q30}) : signed'({3'b000, r_x});
                    n_k     = r_cos ? 4'd1 : 4'd2;
                    n_cnt   = 3'd0;
                    n_state = S_TMUL;
                end
                S_TMUL: begin
                    n_term  = res[60:30];
                    n_state = S_TDIV;
                end
                S_TDIV: begin
                    n_sum = sum_step;
                    n_k   = r_k + 4'd2;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        n_term  = v_sat;
                        n_state = S_MAG;
                    end else begin
                        n_term  = res[30:0];
                        n_state = S_TMUL;
                    end
                end
                S_MAG: begin
                    n_m     = mag_w[44:30];
                    n_state = S_PM1;
                end
                S_PM1: begin
                    n_pm1   = res[31:0];
                    n_state = S_PM2;
                end
                S_PM2: begin
                    n_cmp[r_phase] = c_sat;
                    if (r_phase == 2'd2) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_phase = r_phase + 2'd1;
                        n_i     = IW'(nxt_idx);
                        n_state = S_ANG;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_ia    <= n_ia;
        r_i     <= n_i;
        r_n3    <= n_n3;
        r_n23   <= n_n23;
        r_tt    <= n_tt;
        r_cos   <= n_cos;
        r_sgn   <= n_sgn;
        r_x     <= n_x;
        r_x2    <= n_x2;
        r_term  <= n_term;
        r_sum   <= n_sum;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_m     <= n_m;
        r_pm1   <= n_pm1;
        r_cmp   <= n_cmp;
    end

    assign o_done = r_done;
    assign o_cmp  = r_cmp;

endmodule

// ===== rtl/three_phase_sine_pwm_generator.sv =====
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_ready   i_command, i_fault_n
// output    out        o_valid / i_ready   o_compare_a/b/c, o_run_state, o_outputs_on
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A start, stop or fault poll word, and a tick that does not update the compares,
// gives its result word in the cycle after acceptance.
// A tick that updates the compares takes 56 multiply or divide operations, all run
// in turn on the one shift-and-add unit.
// Reset is synchronous and active low; it needs no clearing pass.
// A new word is taken while a result waits only if that result is taken in the same cycle.
module three_phase_sine_pwm_generator #(
    parameter int TABLE_MAX     = tps_pkg::TABLE_MAX_DEF,
    parameter int PERIOD_COUNTS = tps_pkg::PERIOD_COUNTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_command,
    input  logic                        i_fault_n,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tps_pkg::CMP_W-1:0]   o_compare_a,
    output logic [tps_pkg::CMP_W-1:0]   o_compare_b,
    output logic [tps_pkg::CMP_W-1:0]   o_compare_c,
    output logic [1:0]                  o_run_state,
    output logic                        o_outputs_on,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tps_pkg::CFG_W-1:0]   i_cfg_data
);
    import tps_pkg::*;

    localparam int IW = $clog2(TABLE_MAX);
    localparam int NW = $clog2(TABLE_MAX + 1);

    t_mode              r_mode, n_mode;
    logic               r_busy, n_busy;
    logic               r_ovalid, n_ovalid;
    logic [MOD_W-1:0]   r_mod, n_mod;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [IW-1:0]      r_idx, n_idx;
    t_cmp3              r_held, n_held;

    logic               accept;
    logic               go;
    logic [15:0]        steps16;
    logic [NW-1:0]      w_n;
    logic [NW:0]        idx_inc;
    logic [MOD_W-1:0]   w_modc;
    logic               seq_done;
    t_cmp3              seq_cmp;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    assign o_ready = !r_busy && (!r_ovalid || i_ready);
    assign accept  = i_valid && o_ready;

    always_comb begin
        steps16 = 16'(r_steps);
        if (steps16 < 16'd4) begin
            w_n = NW'(4);
        end else if (steps16 > 16'(TABLE_MAX)) begin
            w_n = NW'(TABLE_MAX);
        end else begin
            w_n = NW'(steps16);
        end
        w_modc  = (r_mod > MOD_ONE) ? MOD_ONE : r_mod;
        idx_inc = (NW+1)'(r_idx) + (NW+1)'(1);
    end

    always_comb begin
        n_mode   = r_mode;
        n_busy   = r_busy;
        n_ovalid = r_ovalid;
        n_mod    = r_mod;
        n_steps  = r_steps;
        n_idx    = r_idx;
        n_held   = r_held;
        go       = 1'b0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        if (accept) begin
            n_ovalid = 1'b1;
            unique case (i_command)
                CMD_START: begin
                    if (r_mode != MODE_FAULT) begin
                        if (!i_fault_n) begin
                            n_mode = MODE_FAULT;
                        end else begin
                            n_mode = MODE_RUN;
                            n_idx  = '0;
                        end
                    end
                end
                CMD_STOP: begin
                    n_mode = MODE_IDLE;
                end
                CMD_TICK, CMD_POLL: begin
                    if (r_mode == MODE_RUN) begin
                        if (!i_fault_n) begin
                            n_mode = MODE_FAULT;
                        end else if (i_command == CMD_TICK) begin
                            go       = 1'b1;
                            n_busy   = 1'b1;
                            n_ovalid = 1'b0;
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
        if (seq_done) begin
            n_busy   = 1'b0;
            n_ovalid = 1'b1;
            n_held   = seq_cmp;
            n_idx    = (idx_inc == {1'b0, w_n}) ? '0 : IW'(idx_inc);
        end
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOD_IDX: begin
                    n_mod = i_cfg_data;
                end
                CFG_STEPS_IDX: begin
                    n_steps = i_cfg_data[STEPS_W-1:0];
                    n_idx   = '0;
                end
                default: begin
                    n_mod = r_mod;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_mod    <= MOD_RESET;
            r_steps  <= STEPS_RESET;
            r_idx    <= '0;
            r_held   <= {3{CMP_W'(PERIOD_COUNTS / 2)}};
        end else begin
            r_mode   <= n_mode;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_mod    <= n_mod;
            r_steps  <= n_steps;
            r_idx    <= n_idx;
            r_held   <= n_held;
        end
    end

    tps_seq #(
        .TABLE_MAX     (TABLE_MAX),
        .PERIOD_COUNTS (PERIOD_COUNTS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (go),
        .i_idx   (r_idx),
        .i_n     (w_n),
        .i_mod   (w_modc),
        .o_done  (seq_done),
        .o_cmp   (seq_cmp),
        .o_req   (alu_req),
        .i_rsp   (alu_rsp)
    );

    tps_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        unique case (r_mode)
            MODE_IDLE:  o_run_state = RUN_STATE_IDLE;
            MODE_RUN:   o_run_state = RUN_STATE_RUN;
            MODE_FAULT: o_run_state = RUN_STATE_FAULT;
            default:    o_run_state = RUN_STATE_IDLE;
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_outputs_on = (r_mode == MODE_RUN);
    assign o_compare_a  = r_held[0];
    assign o_compare_b  = r_held[1];
    assign o_compare_c  = r_held[2];

endmodule

// ===== rtl/tps_checker.sv =====
`include "three_phase_sine_pwm_generator_assert.svh"

module tps_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [1:0]                i_command,
    input logic                      i_fault_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [tps_pkg::CMP_W-1:0] o_compare_a,
    input logic [tps_pkg::CMP_W-1:0] o_compare_b,
    input logic [tps_pkg::CMP_W-1:0] o_compare_c,
    input logic [1:0]                o_run_state,
    input logic                      o_outputs_on
);
    import tps_pkg::*;

    `TPS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_compare_a) && $stable(o_compare_b) && $stable(o_compare_c) && $stable(o_run_state))

    `TPS_ASSERT_NOW(a_on_matches_state, o_valid, o_outputs_on == (o_run_state == RUN_STATE_RUN))

    `TPS_ASSERT_NOW(a_cmp_nonzero, o_valid, o_compare_a != 16'd0 && o_compare_b != 16'd0 && o_compare_c != 16'd0)

    `TPS_ASSERT_NEXT(a_stop_idles, i_valid && o_ready && i_command == CMD_STOP, o_valid && o_run_state == RUN_STATE_IDLE)

    `TPS_ASSERT_NEXT(a_start_fault, i_valid && o_ready && i_command == CMD_START && !i_fault_n, o_valid && o_run_state == RUN_STATE_FAULT)

endmodule

bind three_phase_sine_pwm_generator tps_checker u_tps_checker (.*);

// ===== sim/spwm_compare_checker.sv =====
module spwm_compare_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_ready_in,
    input  logic [1:0]                i_command,
    input  logic                      i_fault_n,
    input  logic                      i_valid_out,
    input  logic                      i_ready,
    input  logic [tps_pkg::CMP_W-1:0] i_compare_a,
    input  logic [tps_pkg::CMP_W-1:0] i_compare_b,
    input  logic [tps_pkg::CMP_W-1:0] i_compare_c,
    input  logic [1:0]                i_run_state,
    input  logic                      i_outputs_on,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [tps_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import tps_pkg::*;

    localparam longint HALF = PERIOD_COUNTS_DEF / 2;

    typedef struct {
        logic [CMP_W-1:0] cmp_a;
        logic [CMP_W-1:0] cmp_b;
        logic [CMP_W-1:0] cmp_c;
        logic [1:0]       run_state;
        logic             outputs_on;
    } t_status_word;

    t_status_word     expected_words[$];
    logic [MOD_W-1:0]   depth;
    logic [STEPS_W-1:0] steps_raw;
    logic [9:0]         step_pos;
    logic [1:0]         run_mode;
    logic [CMP_W-1:0]   held[3];

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned turn_to_rad(int unsigned t);
        return ((longint'(t) * longint'(PI_Q30)) + 16384) >> 15;
    endfunction

    function automatic longint taylor(longint unsigned x, longint unsigned first,
                                      int unsigned k0);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int unsigned     k;
        x2 = qmul(x, x);
        term = first;
        sum = longint'(first);
        k = k0;
        for (int i = 0; i < 6; i++) begin
            term = qmul(term, x2) / (longint'(k) * (k + 1));
            if (i % 2 == 0) sum -= longint'(term);
            else sum += longint'(term);
            k += 2;
        end
        return sum;
    endfunction

    function automatic longint sine_magnitude(int unsigned t);
        longint v;
        if (t <= 8192) v = taylor(turn_to_rad(t), turn_to_rad(t), 2);
        else v = taylor(turn_to_rad(16384 - t), longint'(ONE_Q30), 1);
        if (v < 0) v = 0;
        if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
        return (v * 32767 + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint sine_q15(logic [15:0] a16);
        longint m;
        if (a16[14]) m = sine_magnitude(16384 - int'(a16[13:0]));
        else m = sine_magnitude(int'(a16[13:0]));
        return a16[15] ? -m : m;
    endfunction

    function automatic logic [CMP_W-1:0] predict_compare(int unsigned idx, int unsigned n);
        longint      md;
        logic [15:0] a16;
        longint      c;
        md = (depth > MOD_ONE) ? 65536 : longint'(depth);
        a16 = 16'((longint'(idx) * 65536) / n);
        c = HALF + ((HALF * md * sine_q15(a16)) >>> 31);
        if (c < 1) c = 1;
        if (c > PERIOD_COUNTS_DEF - 1) c = PERIOD_COUNTS_DEF - 1;
        return c[CMP_W-1:0];
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        int unsigned  n;
        int unsigned  ia;
        t_status_word w;
        if (!i_rst_n) begin
            depth <= MOD_RESET;
            steps_raw <= STEPS_RESET;
            step_pos <= '0;
            run_mode <= RUN_STATE_IDLE;
            for (int i = 0; i < 3; i++) held[i] <= CMP_W'(HALF);
            expected_words.delete();
        end else begin
            if (i_valid_out && i_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t unexpected word: expected none actual a=%0d", $time,
                             i_compare_a);
                    o_fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("compare_a", w.cmp_a, i_compare_a);
                    check_field("compare_b", w.cmp_b, i_compare_b);
                    check_field("compare_c", w.cmp_c, i_compare_c);
                    check_field("run_state", w.run_state, i_run_state);
                    check_field("outputs_on", w.outputs_on, i_outputs_on);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MOD_IDX) depth <= i_cfg_data;
                else begin
                    steps_raw <= i_cfg_data[STEPS_W-1:0];
                    step_pos <= '0;
                end
            end
            if (i_valid && i_ready_in) begin
                n = (steps_raw < 4) ? 4 : (steps_raw > TABLE_MAX_DEF) ? TABLE_MAX_DEF
                                                                       : steps_raw;
                w.run_state = run_mode;
                w.cmp_a = held[0];
                w.cmp_b = held[1];
                w.cmp_c = held[2];
                if (i_command == CMD_START) begin
                    if (run_mode != RUN_STATE_FAULT) begin
                        if (!i_fault_n) w.run_state = RUN_STATE_FAULT;
                        else begin
                            w.run_state = RUN_STATE_RUN;
                            step_pos <= '0;
                        end
                    end
                end else if (i_command == CMD_STOP) begin
                    w.run_state = RUN_STATE_IDLE;
                end else if (run_mode == RUN_STATE_RUN) begin
                    if (!i_fault_n) w.run_state = RUN_STATE_FAULT;
                    else if (i_command == CMD_TICK) begin
                        ia = step_pos % n;
                        w.cmp_a = predict_compare(ia, n);
                        w.cmp_b = predict_compare((ia + n / 3) % n, n);
                        w.cmp_c = predict_compare((ia + (2 * n) / 3) % n, n);
                        step_pos <= 10'((ia + 1) % n);
                    end
                end
                w.outputs_on = (w.run_state == RUN_STATE_RUN);
                run_mode <= w.run_state;
                held[0] <= w.cmp_a;
                held[1] <= w.cmp_b;
                held[2] <= w.cmp_c;
                expected_words.push_back(w);
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== sim/tb_three_phase_sine_pwm_generator.sv =====
module tb_three_phase_sine_pwm_generator;
    import tps_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_command;
    logic               i_fault_n;
    logic               o_valid;
    logic               i_ready;
    logic [CMP_W-1:0]   o_compare_a;
    logic [CMP_W-1:0]   o_compare_b;
    logic [CMP_W-1:0]   o_compare_c;
    logic [1:0]         o_run_state;
    logic               o_outputs_on;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    int                 fail_count;
    int                 pending;
    bit                 gaps_on;
    int                 stall_left;
    int                 quiet_cycles;

    three_phase_sine_pwm_generator DUT (.*);

    spwm_compare_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_command(i_command), .i_fault_n(i_fault_n), .i_valid_out(o_valid),
        .i_ready(i_ready), .i_compare_a(o_compare_a), .i_compare_b(o_compare_b),
        .i_compare_c(o_compare_c), .i_run_state(o_run_state),
        .i_outputs_on(o_outputs_on), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls in short random bursts while gaps are enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 40000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic fault_n);
        bit taken;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_fault_n <= fault_n;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_data <= CFG_W'($urandom);
    endtask

    task automatic run_phase(input int count);
        int r;
        send_word(CMD_START, 1'b1);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_word(CMD_TICK, ($urandom_range(0, 49) != 0));
            else if (r < 78) send_word(CMD_POLL, ($urandom_range(0, 9) != 0));
            else if (r < 88) send_word(CMD_START, ($urandom_range(0, 7) != 0));
            else if (r < 94) send_word(CMD_STOP, 1'($urandom));
            else send_word(2'($urandom), 1'($urandom));
            if (o_run_state != RUN_STATE_RUN && $urandom_range(0, 2) == 0) begin
                send_word(CMD_STOP, 1'($urandom));
                send_word(CMD_START, 1'b1);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] depth_pick;
        logic [CFG_W-1:0] steps_pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_TICK;
        i_fault_n = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MOD_IDX;
        i_cfg_data = '0;
        gaps_on = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_TICK, 1'b1);
        send_word(CMD_POLL, 1'b0);
        send_word(CMD_START, 1'b0);
        send_word(CMD_START, 1'b1);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_STOP, 1'b0);
        send_word(CMD_START, 1'b1);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_START, 1'b1);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_POLL, 1'b1);
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_STOP, 1'b1);
        send_word(CMD_START, 1'b1);
        send_word(CMD_POLL, 1'b0);
        write_reg(CFG_MOD_IDX, 17'h1FFFF);
        write_reg(CFG_STEPS_IDX, 17'd0);
        send_word(CMD_STOP, 1'b1);
        send_word(CMD_START, 1'b1);
        repeat (5) send_word(CMD_TICK, 1'b1);
        write_reg(CFG_MOD_IDX, 17'd0);
        write_reg(CFG_STEPS_IDX, 17'h7FF);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_START, 1'b1);
        send_word(CMD_TICK, 1'b1);

        for (int p = 0; p < 9; p++) begin
            case ($urandom_range(0, 3))
                0: depth_pick = MOD_ONE;
                1: depth_pick = 17'h1FFFF;
                2: depth_pick = 17'd0;
                default: depth_pick = CFG_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: steps_pick = CFG_W'($urandom_range(0, 3));
                1: steps_pick = CFG_W'({$urandom_range(0, 63), 11'h7FF});
                2: steps_pick = CFG_W'($urandom_range(1020, 1030));
                default: steps_pick = CFG_W'($urandom_range(4, 13) | ($urandom & 32'h1F800));
            endcase
            write_reg(CFG_MOD_IDX, depth_pick);
            write_reg(CFG_STEPS_IDX, steps_pick);
            if (p == 8) gaps_on = 1'b0;
            run_phase(158);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
